// File: sv/nps_pkg.sv
// Shared types and codes for the nearest point search block.
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 10;
    localparam int DIST_W   = 34;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Marks one point moving down the scan pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } nps_tag_t;

endpackage

`default_nettype wire

// File: sv/nps_point_mem.sv
// Point store: single write port, registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nps_point_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 48
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/nps_dist_unit.sv
// Pipelined squared-distance unit: one point per cycle, abs diff, square, sum.
`timescale 1ns / 1ps
`default_nettype none

module nps_dist_unit #(
    parameter int CB     = 16,
    parameter int ADDR_W = 10,
    parameter int CMP_W  = 34
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nps_pkg::nps_tag_t    in_tag,
    input  wire logic [ADDR_W-1:0]    in_idx,
    input  wire logic [3*CB-1:0]      point,
    input  wire logic signed [CB-1:0] qx,
    input  wire logic signed [CB-1:0] qy,
    input  wire logic signed [CB-1:0] qz,
    output nps_pkg::nps_tag_t         out_tag,
    output logic [ADDR_W-1:0]         out_idx,
    output logic [CMP_W-1:0]          dist_sq
);

    import nps_pkg::*;

    localparam int SUM_W = 2 * CB + 2;

    logic signed [CB:0]   diff [3];
    logic [CB-1:0]        mag_next [3];
    logic [CB-1:0]        mag_reg [3];
    logic [2*CB-1:0]      sq_reg [3];
    logic [SUM_W-1:0]     sum_full;
    logic [CMP_W-1:0]     dist_next;
    logic [CMP_W-1:0]     dist_reg;
    logic signed [CB-1:0] pc [3];
    logic signed [CB-1:0] qc [3];

    nps_tag_t            tag1_reg, tag2_reg, tag3_reg;
    logic [ADDR_W-1:0]   idx1_reg, idx2_reg, idx3_reg;

    always_comb
    begin
        pc[0] = point[CB-1:0];
        pc[1] = point[2*CB-1:CB];
        pc[2] = point[3*CB-1:2*CB];
        qc[0] = qx;
        qc[1] = qy;
        qc[2] = qz;
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = {pc[k][CB-1], pc[k]} - {qc[k][CB-1], qc[k]};
            if (diff[k][CB])
            begin
                mag_next[k] = CB'(-diff[k]);
            end
            else
            begin
                mag_next[k] = diff[k][CB-1:0];
            end
        end
    end

    always_comb
    begin
        sum_full = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        if ((sum_full >> CMP_W) != '0)
        begin
            dist_next = '1;
        end
        else
        begin
            dist_next = sum_full[CMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= mag_next[k];
            sq_reg[k]  <= mag_reg[k] * mag_reg[k];
        end
        dist_reg <= dist_next;
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag = tag3_reg;
    assign out_idx = idx3_reg;
    assign dist_sq = dist_reg;

endmodule

`default_nettype wire

// File: sv/nearest_point_search.sv
// Top level of the brute-force 3-D nearest point search block.
//
// Command port: a request is taken on a rising edge with start high and
// busy low. op selects insert, query or clear; coord_x/y/z carry the point.
// Each request gives exactly one result, shown for one cycle with done high
// on status, nearest_index and distance_sq. The receiver cannot stall.
//
// Insert, clear and unused op codes: done is high in the cycle after the
// request; busy stays low, so a new request may follow at once.
// Query on a non-empty store of N points: one point is read from the store
// and fed to the distance pipeline each cycle; done rises when the last
// point leaves it, and busy is high until then. Throughput is set by the
// one read port of the point store; an empty-store query keeps busy low.
//
// Reset clears the point count and all control; store contents are left
// as they are and are never read until written again.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [nps_pkg::OP_W-1:0]      op,
    input  wire logic signed [COORD_BITS-1:0]  coord_x,
    input  wire logic signed [COORD_BITS-1:0]  coord_y,
    input  wire logic signed [COORD_BITS-1:0]  coord_z,
    output logic                               done,
    output logic [nps_pkg::STATUS_W-1:0]       status,
    output logic [nps_pkg::IDX_W-1:0]          nearest_index,
    output logic [nps_pkg::DIST_W-1:0]         distance_sq
);

    import nps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 2 * COORD_BITS + 2;
    localparam int CMP_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int EXT_W  = (CMP_W > DIST_W) ? CMP_W : DIST_W;
    localparam int IX_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;

    logic                   accept;
    logic [CNT_W-1:0]       cnt_m1;
    logic [ADDR_W-1:0]      last_addr;
    logic                   wr_en;
    logic                   rd_en;
    logic [3*COORD_BITS-1:0] rd_data;

    nps_tag_t               iss_tag;
    nps_tag_t               rd_tag_reg;
    logic [ADDR_W-1:0]      rd_idx_reg;

    nps_tag_t               d_tag;
    logic [ADDR_W-1:0]      d_idx;
    logic [CMP_W-1:0]       d_dist;

    logic [CMP_W-1:0]       best_dist_reg, best_dist_next;
    logic [ADDR_W-1:0]      best_idx_reg, best_idx_next;
    logic                   better;

    logic                   done_reg, done_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;

    logic [IX_W-1:0]        ins_ix_ext;
    logic [IX_W-1:0]        best_ix_ext;
    logic [EXT_W-1:0]       best_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign last_addr = cnt_m1[ADDR_W-1:0];
    assign wr_en     = accept && (op == OP_INSERT) && (count_reg < CNT_W'(MAX_POINTS));
    assign rd_en     = (state_reg == S_SCAN);

    always_comb
    begin
        iss_tag.valid = (state_reg == S_SCAN);
        iss_tag.last  = (state_reg == S_SCAN) && (addr_reg == last_addr);
    end

    nps_point_mem #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W),
        .DATA_W (3 * COORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({coord_z, coord_y, coord_x}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    nps_dist_unit #(
        .CB     (COORD_BITS),
        .ADDR_W (ADDR_W),
        .CMP_W  (CMP_W)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (rd_tag_reg),
        .in_idx  (rd_idx_reg),
        .point   (rd_data),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .qz      (qz_reg),
        .out_tag (d_tag),
        .out_idx (d_idx),
        .dist_sq (d_dist)
    );

    // Running minimum; strict compare keeps the lowest index on ties
    always_comb
    begin
        better = (d_idx == '0) || (d_dist < best_dist_reg);
        if (better)
        begin
            best_dist_next = d_dist;
            best_idx_next  = d_idx;
        end
        else
        begin
            best_dist_next = best_dist_reg;
            best_idx_next  = best_idx_reg;
        end
        ins_ix_ext  = IX_W'(count_reg[ADDR_W-1:0]);
        best_ix_ext = IX_W'(best_idx_next);
        best_ext    = EXT_W'(best_dist_next);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        dist_next   = dist_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    index_next  = '0;
                    dist_next   = '0;
                    priority if (op == OP_INSERT)
                    begin
                        if (count_reg < CNT_W'(MAX_POINTS))
                        begin
                            index_next = ins_ix_ext[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else if (op == OP_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            addr_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (op == OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg;
                    end
                end
            end
            S_SCAN:
            begin
                if (addr_reg == last_addr)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            S_WAIT:
            begin
                if (d_tag.valid && d_tag.last)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    index_next  = best_ix_ext[IDX_W-1:0];
                    if (best_ext > EXT_W'(DIST_MAX))
                    begin
                        dist_next = DIST_MAX;
                    end
                    else
                    begin
                        dist_next = best_ext[DIST_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            addr_reg   <= '0;
            done_reg   <= 1'b0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            done_reg   <= done_next;
            rd_tag_reg <= iss_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qz_reg <= coord_z;
        end
        if (d_tag.valid)
        begin
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
        end
        rd_idx_reg <= addr_reg;
        status_reg <= status_next;
        index_reg  <= index_next;
        dist_reg   <= dist_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign nearest_index = index_reg;
    assign distance_sq   = dist_reg;

endmodule

`default_nettype wire
